// ----- rtl/gfm_pkg.sv -----
// ----------------------------------------------------------------------------
// gfm_pkg
// Shared types and constants of the gated frequency meter.
// ----------------------------------------------------------------------------
package gfm_pkg;

  localparam int EDGE_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int HZ_W      = 23;
  localparam int CFG_IDX_W = 2;

  localparam int SCALE_W   = 10;
  localparam int PROD_W    = EDGE_BITS + WORD_W;
  localparam int NUM_W     = PROD_W + SCALE_W;
  localparam int REM_W     = WORD_W + 1;

  localparam int DIV_MHZ_STEPS = WORD_W;
  localparam int CNT_W         = $clog2(DIV_MHZ_STEPS);

  localparam int HZ_PRE_SHIFT   = 3;
  localparam int HZ_ARG_W       = WORD_W + 1 - HZ_PRE_SHIFT;
  localparam int HZ_RECIP_W     = 31;
  localparam int HZ_PROD_W      = HZ_ARG_W + HZ_RECIP_W;
  localparam int HZ_RECIP_SHIFT = 37;

  localparam logic [SCALE_W-1:0]    MILLI_SCALE = SCALE_W'(1000);
  localparam logic [WORD_W-1:0]     HZ_ROUND    = WORD_W'(500);
  localparam logic [HZ_RECIP_W-1:0] HZ_RECIP    = 31'd1099511628;
  localparam logic [WORD_W-1:0]     SAT_VALUE   = {WORD_W{1'b1}};

  localparam logic [WORD_W-1:0] CLOCK_HZ_RESET = WORD_W'(72000000);
  localparam logic [WORD_W-1:0] INTERVAL_RESET = WORD_W'(36000000);

  localparam logic [CFG_IDX_W-1:0] REG_CORE_CLOCK_HZ   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL1,
    ST_MUL2,
    ST_CHECK,
    ST_DIV_MHZ,
    ST_STORE_MHZ,
    ST_START_HZ,
    ST_MUL_HZ,
    ST_STORE_HZ,
    ST_DONE
  } gfm_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul1;
    logic mul2;
    logic check;
    logic div_step;
    logic mul_hz;
    logic store_mhz;
    logic start_hz;
    logic store_hz;
    logic out_load;
  } gfm_cmd_t;

  typedef struct packed {
    logic take;
    logic sat_big;
    logic div_last;
  } gfm_status_t;

endpackage

// ----- rtl/gfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// gfm_ctrl
// Sequencer of the meter: steps one poll through evaluation, then if it measures
// the multiplies, the serial divide and hertz scaling, then the output register.
// ----------------------------------------------------------------------------
module gfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  gfm_pkg::gfm_status_t status,
  output gfm_pkg::gfm_cmd_t    cmd
);
  import gfm_pkg::*;

  gfm_state_t state;
  gfm_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = status.take ? ST_MUL1 : ST_DONE;
      end
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = status.sat_big ? ST_START_HZ : ST_DIV_MHZ;
      end
      ST_DIV_MHZ: begin
        if (status.div_last) begin
          state_next = ST_STORE_MHZ;
        end
      end
      ST_STORE_MHZ: state_next = ST_START_HZ;
      ST_START_HZ:  state_next = ST_MUL_HZ;
      ST_MUL_HZ:    state_next = ST_STORE_HZ;
      ST_STORE_HZ:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EVAL:      cmd.eval = 1'b1;
      ST_MUL1:      cmd.mul1 = 1'b1;
      ST_MUL2:      cmd.mul2 = 1'b1;
      ST_CHECK:     cmd.check = 1'b1;
      ST_DIV_MHZ:   cmd.div_step = 1'b1;
      ST_STORE_MHZ: cmd.store_mhz = 1'b1;
      ST_START_HZ:  cmd.start_hz = 1'b1;
      ST_MUL_HZ:    cmd.mul_hz = 1'b1;
      ST_STORE_HZ:  cmd.store_hz = 1'b1;
      ST_DONE:      cmd.out_load = out_free;
      default:      cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/gfm_datapath.sv -----
// ----------------------------------------------------------------------------
// gfm_datapath
// Configuration registers, measurement state, multipliers, the restoring
// divider, the reciprocal multiply for hertz and the output register.
// ----------------------------------------------------------------------------
module gfm_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfm_pkg::WORD_W-1:0]     cfg_data,
  input  logic [gfm_pkg::WORD_W-1:0]     poll_cycle,
  input  logic [gfm_pkg::EDGE_BITS-1:0]  edge_count,
  input  gfm_pkg::gfm_cmd_t              cmd,
  output gfm_pkg::gfm_status_t           status,
  output logic                           updated,
  output logic [gfm_pkg::WORD_W-1:0]     freq_millihz,
  output logic [gfm_pkg::HZ_W-1:0]       freq_hz,
  output logic                           saturated
);
  import gfm_pkg::*;

  logic [WORD_W-1:0]    core_clock_hz;
  logic [WORD_W-1:0]    update_interval;

  logic [WORD_W-1:0]    last_cycle;
  logic [EDGE_BITS-1:0] last_edges;
  logic [WORD_W-1:0]    millihz_value;
  logic                 sat_flag;
  logic [HZ_W-1:0]      hz_value;

  logic [WORD_W-1:0]    now_reg;
  logic [EDGE_BITS-1:0] edges_reg;
  logic                 take_reg;
  logic [WORD_W-1:0]    div_reg;
  logic [EDGE_BITS-1:0] delta;
  logic [PROD_W-1:0]    prod;
  logic [NUM_W-1:0]     numer;

  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     quo;
  logic [CNT_W-1:0]     div_count;

  logic [HZ_ARG_W-1:0]  hz_arg;
  logic [HZ_PROD_W-1:0] hz_prod;

  logic [WORD_W-1:0]    elapsed;
  logic                 take;
  logic [REM_W-1:0]     shifted;
  logic [REM_W-1:0]     divisor;
  logic                 fits;
  logic [REM_W-1:0]     rem_next;
  logic [WORD_W:0]      hz_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_clock_hz   <= CLOCK_HZ_RESET;
      update_interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CORE_CLOCK_HZ:   core_clock_hz <= cfg_data;
        REG_UPDATE_INTERVAL: update_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign elapsed = now_reg - last_cycle;
  assign take    = (elapsed != '0) && (elapsed >= update_interval);

  assign shifted  = {rem[WORD_W-1:0], quo[REM_W-1]};
  assign divisor  = {1'b0, div_reg};
  assign fits     = shifted >= divisor;
  assign rem_next = fits ? (shifted - divisor) : shifted;

  assign hz_sum = {1'b0, millihz_value} + {1'b0, HZ_ROUND};

  assign status.take     = take;
  assign status.sat_big  = (numer >> WORD_W) >= NUM_W'(div_reg);
  assign status.div_last = (div_count == CNT_W'(DIV_MHZ_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_reg   <= poll_cycle;
      edges_reg <= edge_count;
    end
    if (cmd.eval) begin
      take_reg <= take;
      div_reg  <= elapsed;
      delta    <= edges_reg - last_edges;
    end
    if (cmd.mul1) begin
      prod <= PROD_W'(delta) * PROD_W'(core_clock_hz);
    end
    if (cmd.mul2) begin
      numer <= NUM_W'(prod) * NUM_W'(MILLI_SCALE);
    end
    if (cmd.check) begin
      rem       <= REM_W'(numer >> WORD_W);
      quo       <= {numer[WORD_W-1:0], 1'b0};
      div_count <= '0;
    end else if (cmd.div_step) begin
      rem       <= rem_next;
      quo       <= {quo[REM_W-2:0], fits};
      div_count <= div_count + CNT_W'(1);
    end
    if (cmd.start_hz) begin
      hz_arg <= hz_sum[WORD_W:HZ_PRE_SHIFT];
    end
    if (cmd.mul_hz) begin
      hz_prod <= HZ_PROD_W'(hz_arg) * HZ_PROD_W'(HZ_RECIP);
    end
    if (cmd.out_load) begin
      updated      <= take_reg;
      freq_millihz <= millihz_value;
      freq_hz      <= hz_value;
      saturated    <= sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_cycle    <= '0;
      last_edges    <= '0;
      millihz_value <= '0;
      sat_flag      <= 1'b0;
      hz_value      <= '0;
    end else begin
      if (cmd.eval && take) begin
        last_cycle <= now_reg;
        last_edges <= edges_reg;
      end
      if (cmd.check && status.sat_big) begin
        millihz_value <= SAT_VALUE;
        sat_flag      <= 1'b1;
      end else if (cmd.store_mhz) begin
        millihz_value <= quo[WORD_W-1:0];
        sat_flag      <= 1'b0;
      end
      if (cmd.store_hz) begin
        hz_value <= hz_prod[HZ_RECIP_SHIFT +: HZ_W];
      end
    end
  end

endmodule

// ----- rtl/gated_frequency_meter.sv -----
// ----------------------------------------------------------------------------
// gated_frequency_meter
// Frequency meter that gates a free-running edge count with a cycle
// timestamp and reports the result in millihertz and in hertz.
// ----------------------------------------------------------------------------
// Each beat on the input channel carries a cycle timestamp and an edge count.
// Every input beat yields exactly one output beat that reports the stored
// frequency and whether this poll took a new measurement.
// A poll that is too early goes from acceptance through the evaluation state
// straight to the output register. A poll that measures passes through the
// two multiplies, the 32 steps of the radix-2 divider for the millihertz
// quotient and the hertz scaling. When the quotient saturates the divider is
// skipped. The hertz value comes from a reciprocal multiply in the states
// ST_START_HZ, ST_MUL_HZ and ST_STORE_HZ. One poll is in work at a time, so
// the input is stalled until the result has been loaded into the output
// register.
// The output register holds its beat while out_stall is high; the next
// poll may be accepted and worked on meanwhile and waits only at its end.
// Configuration writes are always ready and are meant for idle periods.
// Reset restores the default clock and interval and clears the stored
// timestamp, edge count, frequency and saturation flag.
// ----------------------------------------------------------------------------
module gated_frequency_meter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gfm_pkg::WORD_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gfm_pkg::WORD_W-1:0]     poll_cycle,
  input  logic [gfm_pkg::EDGE_BITS-1:0]  edge_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           updated,
  output logic [gfm_pkg::WORD_W-1:0]     freq_millihz,
  output logic [gfm_pkg::HZ_W-1:0]       freq_hz,
  output logic                           saturated
);
  import gfm_pkg::*;

  gfm_cmd_t    cmd;
  gfm_status_t status;

  assign cfg_ready = 1'b1;

  gfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gfm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .poll_cycle   (poll_cycle),
    .edge_count   (edge_count),
    .cmd          (cmd),
    .status       (status),
    .updated      (updated),
    .freq_millihz (freq_millihz),
    .freq_hz      (freq_hz),
    .saturated    (saturated)
  );

endmodule
